// ===== rtl/cft_pkg.sv =====
package cft_pkg;

    // result quotient and input operand width at the ports
    localparam int PORT_W        = 32;
    localparam int DEFAULT_WIDTH = 32;
    localparam int MAX_TERMS     = 48;

    typedef enum logic [0:0] {
        S_IDLE,
        S_DIV
    } t_state;

endpackage

// ===== rtl/cft_div.sv =====
module cft_div #(
    parameter int WIDTH = cft_pkg::DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    import cft_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_run) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(WIDTH - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/continued_fraction_terms_core.sv =====
// each term comes from one restoring division on the shared divider, and the next division
// starts as that term is registered; a zero denominator gives its flagged term without dividing
// one fraction at a time: busy is high while its divisions run, and start is ignored then
// up to 46 terms with 32-bit port operands; every fraction is capped at 48 terms
// terms leave on o_valid for one cycle each; the receiver cannot stall
// reset: synchronous active-low i_rst_n clears the sequencer, divider and strobe
module continued_fraction_terms_core #(
    parameter int WIDTH = cft_pkg::DEFAULT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cft_pkg::PORT_W-1:0] i_numerator,
    input  logic [cft_pkg::PORT_W-1:0] i_denominator,
    output logic                       o_valid,
    output logic [cft_pkg::PORT_W-1:0] o_quotient,
    output logic                       o_last_term,
    output logic                       o_zero_divisor
);
    import cft_pkg::*;

    // common width for widening or narrowing between ports and datapath
    localparam int EXT_W  = (WIDTH > PORT_W) ? WIDTH : PORT_W;
    localparam int TERM_W = $clog2(MAX_TERMS);

    t_state              r_state, n_state;
    logic [TERM_W-1:0]   r_terms, n_terms;
    logic [WIDTH-1:0]    r_den, n_den;
    logic                r_valid, n_valid;
    logic [PORT_W-1:0]   r_quotient, n_quotient;
    logic                r_last, n_last;
    logic                r_zdiv, n_zdiv;

    // operands taken modulo 2^WIDTH
    logic [EXT_W-1:0]    num_ext;
    logic [EXT_W-1:0]    den_ext;
    logic [WIDTH-1:0]    in_num;
    logic [WIDTH-1:0]    in_den;

    // shared divider hookup
    logic                div_start;
    logic [WIDTH-1:0]    div_dividend;
    logic [WIDTH-1:0]    div_divisor;
    logic                div_done;
    logic [WIDTH-1:0]    div_quo;
    logic [WIDTH-1:0]    div_rem;
    logic [EXT_W-1:0]    quo_ext;
    logic                term_last;

    assign num_ext = EXT_W'(i_numerator);
    assign den_ext = EXT_W'(i_denominator);
    assign in_num  = num_ext[WIDTH-1:0];
    assign in_den  = den_ext[WIDTH-1:0];
    assign quo_ext = EXT_W'(div_quo);

    // final term when the remainder is zero or the term cap is reached
    assign term_last = (div_rem == '0) || (r_terms == TERM_W'(MAX_TERMS - 1));

    cft_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_terms      = r_terms;
        n_den        = r_den;
        n_valid      = 1'b0;
        n_quotient   = r_quotient;
        n_last       = r_last;
        n_zdiv       = r_zdiv;
        div_start    = 1'b0;
        div_dividend = in_num;
        div_divisor  = in_den;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (in_den == '0) begin
                        // undefined fraction: single flagged term
                        n_valid    = 1'b1;
                        n_quotient = '0;
                        n_last     = 1'b1;
                        n_zdiv     = 1'b1;
                    end else begin
                        div_start = 1'b1;
                        n_den     = in_den;
                        n_terms   = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // emit this term, then step the pair to (den, rem)
                    n_valid    = 1'b1;
                    n_quotient = quo_ext[PORT_W-1:0];
                    n_last     = term_last;
                    n_zdiv     = 1'b0;
                    n_terms    = r_terms + TERM_W'(1);
                    if (term_last) begin
                        n_state = S_IDLE;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = r_den;
                        div_divisor  = div_rem;
                        n_den        = div_rem;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_terms <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_terms <= n_terms;
            r_valid <= n_valid;
        end
    end

    // result payload and current divisor carry no reset
    always_ff @(posedge i_clk) begin
        r_den      <= n_den;
        r_quotient <= n_quotient;
        r_last     <= n_last;
        r_zdiv     <= n_zdiv;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_quotient     = r_quotient;
    assign o_last_term    = r_last;
    assign o_zero_divisor = r_zdiv;

endmodule
